FILE: rtl/core/dsd_pkg.sv
// Package for the serial sample deframer: config, command and status types,
// register map, parity codes and frame constants. No dependencies.
package dsd_pkg;

    localparam int BAUD_W   = 13;
    localparam int CONF_W   = 7;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int PADDR_W  = 4;

    localparam logic [CONF_W-1:0] CONF_MIN   = 7'd10;
    localparam logic [SLOT_W-1:0] SLOT_IDLE  = 4'd15;
    localparam logic [SLOT_W-1:0] SLOT_START = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_PAR   = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_STOP  = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 4'd10;

    localparam logic [1:0] REG_BAUD   = 2'd0;
    localparam logic [1:0] REG_NBITS  = 2'd1;
    localparam logic [1:0] REG_PARITY = 2'd2;
    localparam logic [1:0] REG_NSTOP  = 2'd3;

    localparam logic [2:0] PAR_OFF   = 3'd0;
    localparam logic [2:0] PAR_ODD   = 3'd1;
    localparam logic [2:0] PAR_EVN   = 3'd2;
    localparam logic [2:0] PAR_MARK  = 3'd3;
    localparam logic [2:0] PAR_SPACE = 3'd4;

    localparam logic [BAUD_W-1:0] BAUD_RST   = 13'd300;
    localparam logic [3:0]        NBITS_RST  = 4'd8;
    localparam logic [3:0]        NBITS_SEVEN = 4'd7;
    localparam logic [2:0]        PARITY_RST = PAR_OFF;
    localparam logic [1:0]        NSTOP_RST  = 2'd1;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [3:0]        nbits;
        logic [2:0]        parity;
        logic [1:0]        nstop;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic conf_ok;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/dsd_regs.sv
// APB-style configuration registers of the deframer.
// Depends on dsd_pkg.
module dsd_regs
    import dsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign idx   = paddr[3:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baud   <= BAUD_RST;
            cfg_reg.nbits  <= NBITS_RST;
            cfg_reg.parity <= PARITY_RST;
            cfg_reg.nstop  <= NSTOP_RST;
        end else if (wr_en) begin
            case (idx)
                REG_BAUD:   cfg_reg.baud   <= pwdata[BAUD_W-1:0];
                REG_NBITS:  cfg_reg.nbits  <= pwdata[3:0];
                REG_PARITY: cfg_reg.parity <= pwdata[2:0];
                REG_NSTOP:  cfg_reg.nstop  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BAUD:   prdata = {{(32-BAUD_W){1'b0}}, cfg_reg.baud};
            REG_NBITS:  prdata = {28'd0, cfg_reg.nbits};
            REG_PARITY: prdata = {29'd0, cfg_reg.parity};
            REG_NSTOP:  prdata = {30'd0, cfg_reg.nstop};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/dsd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependency.
module dsd_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    count_reg;
    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             qbit;

    assign rem_sh = {rem_reg, work_reg[NUM_W-1]};
    assign qbit   = rem_sh >= {1'b0, den_reg};
    assign done   = (count_reg == '0);
    assign quot   = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (start) begin
            count_reg <= CW'(NUM_W);
        end else if (count_reg != '0) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (count_reg != '0) begin
            work_reg <= {work_reg[NUM_W-2:0], qbit};
            rem_reg  <= qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
        end
    end

endmodule

FILE: rtl/core/dsd_datapath.sv
// Deframer datapath: sample counter, slot tracking, data bits, slot time
// divider and output register. Depends on dsd_pkg and dsd_div.
module dsd_datapath
    import dsd_pkg::*;
#(
    parameter int SAMPLE_RATE = 8000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    input  logic              in_bit,
    input  logic [CONF_W-1:0] in_conf,
    output status_t           status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    localparam int NUM_W = $clog2(10 * SAMPLE_RATE + 1);
    localparam logic [NUM_W-1:0] RATE_N = NUM_W'(SAMPLE_RATE);
    localparam logic [NUM_W-1:0] HALF_N = NUM_W'(SAMPLE_RATE / 2);

    logic                    bit_reg;
    logic                    conf_ok_reg;
    logic signed [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic                    mvalid_reg, mvalid_next;
    logic [DATA_W-1:0]       mdata_reg, mdata_next;

    logic [BAUD_W-1:0] baud_eff;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quot;
    logic              div_done;
    logic              nbits7;
    logic              nstop2;
    logic              due;
    logic              frame_end;
    logic [DATA_W-1:0] value;
    logic              par;
    logic              par_fail;

    assign baud_eff = (cfg.baud == '0) ? BAUD_W'(1) : cfg.baud;
    assign num      = (slot_reg == SLOT_IDLE) ? HALF_N : NUM_W'(NUM_W'(slot_reg) * RATE_N);
    assign nbits7   = (cfg.nbits == NBITS_SEVEN);
    assign nstop2   = cfg.nstop[1];

    dsd_div #(
        .NUM_W (NUM_W),
        .DEN_W (BAUD_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num),
        .den     (baud_eff),
        .done    (div_done),
        .quot    (quot)
    );

    assign due       = cnt_reg >= $signed({{(CNT_W-NUM_W){1'b0}}, quot});
    assign frame_end = slot_reg >= (nstop2 ? SLOT_LAST : SLOT_STOP);
    assign value     = nbits7 ? {1'b0, data_reg[DATA_W-2:0]} : data_reg;
    assign par       = ^value;

    always_comb begin
        case (cfg.parity)
            PAR_ODD:   par_fail = (par == data_reg[DATA_W-1]);
            PAR_EVN:   par_fail = (par != data_reg[DATA_W-1]);
            PAR_MARK:  par_fail = !data_reg[DATA_W-1];
            PAR_SPACE: par_fail = data_reg[DATA_W-1];
            default:   par_fail = 1'b0;
        endcase
    end

    always_comb begin
        cnt_next    = cnt_reg;
        slot_next   = slot_reg;
        data_next   = data_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        mdata_next  = mdata_reg;
        if (cmd.latch) begin
            cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 32'sd1;
        end
        if (cmd.apply) begin
            if (slot_reg == SLOT_IDLE) begin
                if (!bit_reg) begin
                    slot_next = SLOT_START;
                    cnt_next  = -$signed({{(CNT_W-NUM_W){1'b0}}, quot});
                end
            end else if (slot_reg > SLOT_LAST) begin
                slot_next = SLOT_IDLE;
            end else if (due) begin
                if ((slot_reg == SLOT_START && bit_reg) || (slot_reg == SLOT_STOP && !bit_reg)) begin
                    slot_next = SLOT_IDLE;
                end else begin
                    if (slot_reg != SLOT_START && slot_reg <= SLOT_PAR) begin
                        data_next[3'(slot_reg - 4'd1)] = bit_reg;
                    end
                    if (frame_end) begin
                        slot_next = SLOT_IDLE;
                        if (!par_fail) begin
                            mvalid_next = 1'b1;
                            mdata_next  = value;
                        end
                    end else begin
                        slot_next = slot_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            slot_reg   <= SLOT_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            slot_reg   <= slot_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        mdata_reg <= mdata_next;
        if (cmd.latch) begin
            bit_reg     <= in_bit;
            conf_ok_reg <= (in_conf >= CONF_MIN);
        end
    end

    assign status.conf_ok  = conf_ok_reg;
    assign status.div_done = div_done;
    assign status.out_free = !mvalid_reg || m_tready;
    assign m_tvalid        = mvalid_reg;
    assign m_tdata         = mdata_reg;

endmodule

FILE: rtl/core/dsd_ctrl.sv
// Deframer controller: sequences sample capture, slot time divide and update.
// Depends on dsd_pkg.
module dsd_ctrl
    import dsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd.latch     = 1'b0;
        cmd.div_start = 1'b0;
        cmd.apply     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.conf_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done && status.out_free) begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/async_serial_sample_deframer.sv
// A usable sample keeps s_tready low from its beat until the bit-serial slot time
// divider (NUM_W bits, NUM_W = clog2(10*SAMPLE_RATE+1)) is done and m_* is free;
// any byte it completes appears on m_* in the same cycle that s_tready returns.
// A sample with confidence below 10 skips the divide. No new beat is taken while
// one is in work. Reset (aresetn low, synchronous) restores the registers,
// clears the counter, returns to waiting for a start bit and drops m_tvalid.
module async_serial_sample_deframer
    import dsd_pkg::*;
#(
    parameter int SAMPLE_RATE = 8000
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [0] sample_bit, [7:1] confidence
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // [7:0] data_byte
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    dsd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dsd_datapath #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_bit   (s_tdata[0]),
        .in_conf  (s_tdata[7:1]),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/core/dsd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends on dsd_pkg and async_serial_sample_deframer.
module dsd_checker
    import dsd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in work");

    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output beat without a sample in work");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind async_serial_sample_deframer dsd_checker u_dsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
